### sv/ptpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptpe_pkg;

    // Record framing
    localparam int unsigned REC_HDR_LAST   = 15;
    localparam int unsigned ETH_HDR_BYTES  = 14;
    localparam int unsigned MIN_HDR_BYTES  = 20;
    localparam int unsigned MIN_FRAME      = 18;

    // Frame offsets counted from the start of the Ethernet header
    localparam int unsigned OFS_ETYPE_HI   = 12;
    localparam int unsigned OFS_ETYPE_LO   = 13;
    localparam int unsigned OFS_IP_VHL     = 14;
    localparam int unsigned OFS_TOTLEN_HI  = 16;
    localparam int unsigned OFS_TOTLEN_LO  = 17;
    localparam int unsigned OFS_PROTO      = 23;
    localparam int unsigned OFS_DST_FIRST  = 30;
    localparam int unsigned OFS_DST_LAST   = 33;
    localparam int unsigned OFS_TCP_MIN    = 34;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  SYN_ACK_FLAGS  = 8'h12;

    // Width of the packed result data, whole bytes
    localparam int unsigned M_TDATA_W      = 80;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_NOT_IPV4 = 3'd2,
        ST_NOT_TCP  = 3'd3,
        ST_BAD_LEN  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    typedef struct packed {
        logic        connection_done;
        status_t     record_status;
        logic        record_end;
        logic [31:0] packet_destination;
        logic [31:0] segment_sequence;
        logic        payload_last;
        logic        payload_valid;
        logic [7:0]  payload_byte;
    } result_t;

endpackage

`default_nettype wire

### sv/ptpe_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ptpe_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register refills in the same cycle its byte moves on.
    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tvalid || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

### sv/ptpe_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ptpe_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        in_byte,
    output logic                   res_valid,
    output ptpe_pkg::result_t      res
);

    import ptpe_pkg::*;

    logic        hdr_reg, hdr_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] cap_reg, cap_next;
    logic [31:0] orig_reg, orig_next;
    logic [7:0]  eth_hi_reg, eth_hi_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [15:0] tot_reg, tot_next;
    logic [5:0]  thl_reg, thl_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] dst_reg, dst_next;
    logic [31:0] rcv_reg, rcv_next;
    phase_t      phase_reg, phase_next;
    status_t     status_reg, status_next;
    logic        keep_reg, keep_next;

    logic        emit;
    logic        last;
    logic        rec_end;
    logic [31:0] t_ofs;
    logic [31:0] pay_end;
    logic [31:0] pay_start;
    logic [15:0] tot_new;
    logic [31:0] orig_full;
    logic [5:0]  thl_new;
    logic        has_payload;
    logic [1:0]  dst_sel;

    // Offsets derived from the captured header lengths.
    assign t_ofs     = 32'(ETH_HDR_BYTES) + 32'(ihl_reg);
    assign pay_end   = 32'(ETH_HDR_BYTES) + 32'(tot_reg);
    assign pay_start = t_ofs + 32'(thl_reg);
    assign tot_new   = {tot_reg[15:8], in_byte};
    assign orig_full = {in_byte, orig_reg[23:0]};
    assign thl_new   = {in_byte[7:4], 2'b00};
    assign has_payload = tot_reg > (16'(ihl_reg) + 16'(thl_reg));
    assign dst_sel   = cnt_reg[1:0] + 2'd2;

    // Next state for one stream byte.
    always_comb begin
        hdr_next    = hdr_reg;
        cnt_next    = cnt_reg + 32'd1;
        cap_next    = cap_reg;
        orig_next   = orig_reg;
        eth_hi_next = eth_hi_reg;
        ihl_next    = ihl_reg;
        tot_next    = tot_reg;
        thl_next    = thl_reg;
        seq_next    = seq_reg;
        dst_next    = dst_reg;
        rcv_next    = rcv_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        keep_next   = keep_reg;
        emit        = 1'b0;
        last        = 1'b0;
        rec_end     = 1'b0;

        if (hdr_reg) begin
            // Record header: timestamps are skipped, lengths are little-endian.
            if (cnt_reg == 32'd0) begin
                cap_next    = '0;
                orig_next   = '0;
                eth_hi_next = '0;
                ihl_next    = '0;
                tot_next    = '0;
                thl_next    = '0;
                seq_next    = '0;
                dst_next    = '0;
                status_next = ST_OK;
                keep_next   = 1'b0;
            end
            if (cnt_reg[3:2] == 2'b10) begin
                cap_next[{cnt_reg[1:0], 3'b000} +: 8] = in_byte;
            end else if (cnt_reg[3:2] == 2'b11) begin
                orig_next[{cnt_reg[1:0], 3'b000} +: 8] = in_byte;
            end
            if (cnt_reg == 32'(REC_HDR_LAST)) begin
                if (cap_reg != orig_full && status_next == ST_OK) begin
                    status_next = ST_TRUNC;
                end
                if (cap_reg == 32'd0) begin
                    if (status_next == ST_OK) begin
                        status_next = ST_BAD_LEN;
                    end
                    rec_end = 1'b1;
                end else begin
                    hdr_next = 1'b0;
                    cnt_next = 32'd0;
                end
            end
        end else begin
            // Fixed-offset Ethernet and IPv4 fields.
            if (cnt_reg == 32'(OFS_ETYPE_HI)) begin
                eth_hi_next = in_byte;
            end else if (cnt_reg == 32'(OFS_ETYPE_LO)) begin
                if ({eth_hi_reg, in_byte} != ETHERTYPE_IPV4 && status_next == ST_OK) begin
                    status_next = ST_NOT_IPV4;
                end
            end else if (cnt_reg == 32'(OFS_IP_VHL)) begin
                ihl_next = {in_byte[3:0], 2'b00};
                if (ihl_next < 6'(MIN_HDR_BYTES) && status_next == ST_OK) begin
                    status_next = ST_BAD_LEN;
                end
            end else if (cnt_reg == 32'(OFS_TOTLEN_HI)) begin
                tot_next = {in_byte, 8'h00};
            end else if (cnt_reg == 32'(OFS_TOTLEN_LO)) begin
                tot_next = tot_new;
                if ((tot_new < 16'(ihl_reg) + 16'(MIN_HDR_BYTES)
                        || 32'(ETH_HDR_BYTES) + 32'(tot_new) > cap_reg)
                        && status_next == ST_OK) begin
                    status_next = ST_BAD_LEN;
                end
            end else if (cnt_reg == 32'(OFS_PROTO)) begin
                if (in_byte != PROTO_TCP && status_next == ST_OK) begin
                    status_next = ST_NOT_TCP;
                end
            end else if (cnt_reg >= 32'(OFS_DST_FIRST) && cnt_reg <= 32'(OFS_DST_LAST)) begin
                dst_next[{dst_sel, 3'b000} +: 8] = in_byte;
            end

            // TCP header fields and payload, placed after the IPv4 header.
            if (cnt_reg >= 32'(OFS_TCP_MIN)) begin
                if (cnt_reg >= t_ofs + 32'd4 && cnt_reg < t_ofs + 32'd8) begin
                    seq_next = {seq_reg[23:0], in_byte};
                end else if (cnt_reg == t_ofs + 32'd12) begin
                    thl_next = thl_new;
                    if ((thl_new < 6'(MIN_HDR_BYTES)
                            || 16'(ihl_reg) + 16'(thl_new) > tot_reg)
                            && status_next == ST_OK) begin
                        status_next = ST_BAD_LEN;
                    end
                end else if (cnt_reg == t_ofs + 32'd13) begin
                    if (status_reg == ST_OK) begin
                        case (phase_reg)
                            PH_SEARCH: begin
                                if (in_byte == SYN_ACK_FLAGS) begin
                                    rcv_next   = dst_reg;
                                    phase_next = PH_COLLECT;
                                    keep_next  = has_payload;
                                end
                            end
                            PH_COLLECT: begin
                                keep_next = has_payload && (dst_reg == rcv_reg);
                                if (in_byte[0]) begin
                                    phase_next = PH_DONE;
                                end
                            end
                            default: begin
                                keep_next = keep_reg;
                            end
                        endcase
                    end
                end else if (keep_reg && cnt_reg >= pay_start && cnt_reg < pay_end) begin
                    emit = 1'b1;
                    if (cnt_reg + 32'd1 == pay_end) begin
                        last      = 1'b1;
                        keep_next = 1'b0;
                    end
                end
            end

            // Last byte of the captured frame closes the record.
            if (cnt_reg + 32'd1 == cap_reg) begin
                rec_end = 1'b1;
                if (cap_reg < 32'(MIN_FRAME) && status_next == ST_OK) begin
                    status_next = ST_BAD_LEN;
                end
            end
        end

        if (rec_end) begin
            hdr_next  = 1'b1;
            cnt_next  = 32'd0;
            keep_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg    <= 1'b1;
            cnt_reg    <= '0;
            cap_reg    <= '0;
            orig_reg   <= '0;
            eth_hi_reg <= '0;
            ihl_reg    <= '0;
            tot_reg    <= '0;
            thl_reg    <= '0;
            seq_reg    <= '0;
            dst_reg    <= '0;
            phase_reg  <= PH_SEARCH;
            status_reg <= ST_OK;
            keep_reg   <= 1'b0;
        end else if (step) begin
            hdr_reg    <= hdr_next;
            cnt_reg    <= cnt_next;
            cap_reg    <= cap_next;
            orig_reg   <= orig_next;
            eth_hi_reg <= eth_hi_next;
            ihl_reg    <= ihl_next;
            tot_reg    <= tot_next;
            thl_reg    <= thl_next;
            seq_reg    <= seq_next;
            dst_reg    <= dst_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
            keep_reg   <= keep_next;
        end
    end

    // The receiver address is written on the SYN-ACK before any read.
    always_ff @(posedge aclk) begin
        if (step) begin
            rcv_reg <= rcv_next;
        end
    end

    // Result for this byte, built from the updated state.
    always_comb begin
        res.payload_byte       = emit ? in_byte : 8'h00;
        res.payload_valid      = emit;
        res.payload_last       = last;
        res.segment_sequence   = seq_next;
        res.packet_destination = dst_next;
        res.record_end         = rec_end;
        res.record_status      = rec_end ? status_next : ST_OK;
        res.connection_done    = (phase_next != PH_SEARCH) && (phase_next != PH_COLLECT);
    end

    assign res_valid = step && (emit || rec_end);

endmodule

`default_nettype wire

### sv/ptpe_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ptpe_out_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    input  wire ptpe_pkg::result_t             res,
    output logic                               out_free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ptpe_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    import ptpe_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // A new result may load when the register is empty or being drained.
    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            res_reg <= res;
        end
    end

    // Pack the result fields onto the stream ports.
    assign m_tvalid = valid_reg;
    assign m_tlast  = res_reg.payload_last;
    assign m_tuser  = res_reg.payload_valid;
    assign m_tdata  = {3'b000,
                       res_reg.connection_done,
                       res_reg.record_status,
                       res_reg.record_end,
                       res_reg.packet_destination,
                       res_reg.segment_sequence,
                       res_reg.payload_byte};

endmodule

`default_nettype wire

### sv/pcap_tcp_payload_extractor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata (lowest bit up)                          tuser          tlast
// s_        in         stream_byte[7:0]                               -              -
// m_        out        payload_byte[7:0], segment_sequence[39:8],     payload_valid  payload_last
//                      packet_destination[71:40], record_end[72],
//                      record_status[75:73], connection_done[76], zero pad
//
// One stream byte is taken per cycle while the result side does not stall; an accepted byte
// is held in the input register, parsed when the result register can load, and its result, if any, is registered there.
// The per-byte work is a set of offset compares and field captures in the parser stage.
// Reset is synchronous and active low; it returns the parser to the start of a record
// header and clears the connection state.
// When m_tready is low the result register holds, the input register fills, and
// s_tready then drops until the result is taken.
module pcap_tcp_payload_extractor_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // stream_byte[7:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ptpe_pkg::M_TDATA_W-1:0]     m_tdata,   // see table above
    output logic                               m_tuser,   // payload_valid
    output logic                               m_tlast    // payload_last
);

    import ptpe_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       out_free;
    logic       take;
    logic       res_valid;
    result_t    res;

    // A byte is parsed when it is held and the result register can load.
    assign take = byte_valid && out_free;

    ptpe_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    ptpe_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (take),
        .in_byte   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    ptpe_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### tb/tb_pcap_tcp_payload_extractor_core.sv
`timescale 1ns / 1ps

module tb_pcap_tcp_payload_extractor_core;
    import ptpe_pkg::*;

    localparam int          STALL_LIMIT  = 4000;
    localparam int          RANDOM_BYTES = 200;
    localparam logic [7:0]  TCP_FIN      = 8'h01;
    localparam logic [7:0]  TCP_ACK      = 8'h10;
    localparam logic [15:0] ETHERTYPE_V6 = 16'h86dd;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    // One capture record as the stimulus describes it.
    typedef struct {
        logic [31:0] cap_len;
        logic [31:0] orig_len;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [15:0] total_len;
        logic [7:0]  proto;
        logic [31:0] dst;
        logic [31:0] seq;
        logic [3:0]  doff;
        logic [7:0]  flags;
    } capture_pkt_t;

    // One output beat of the extractor.
    typedef struct {
        logic [7:0]  data;
        logic        valid;
        logic        last;
        logic [31:0] seq;
        logic [31:0] dst;
        logic        rec_end;
        status_t     status;
        logic        done;
    } payload_or_end_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    payload_or_end_t payload_or_end_q[$];
    int              error_count  = 0;
    int              bytes_sent   = 0;
    int              quiet_cycles = 0;
    int              ready_hold   = 0;
    bit              idle_on      = 1'b1;
    logic [31:0]     receiver_dst = '0;

    // Parser state mirrored for prediction.
    longint unsigned rec_pos;
    logic [31:0]     cap_len_r;
    logic [31:0]     orig_len_r;
    logic [7:0]      etype_hi_r;
    int unsigned     ip_hdr_bytes;
    int unsigned     ip_tot_len;
    int unsigned     tcp_hdr_bytes;
    logic [31:0]     seq_r;
    logic [31:0]     dst_r;
    logic [31:0]     rx_addr;
    phase_t          phase_r;
    status_t         status_r;
    bit              keep_r;

    pcap_tcp_payload_extractor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Per-record fields are cleared at the first header byte.
    function automatic void clear_record_fields();
        cap_len_r     = '0;
        orig_len_r    = '0;
        etype_hi_r    = '0;
        ip_hdr_bytes  = 0;
        ip_tot_len    = 0;
        tcp_hdr_bytes = 0;
        seq_r         = '0;
        dst_r         = '0;
        status_r      = ST_OK;
        keep_r        = 1'b0;
    endfunction

    // The first fault found in a record decides its status.
    function automatic void raise_status(status_t code);
        if (status_r == ST_OK) begin
            status_r = code;
        end
    endfunction

    // Advance the parser by one stream byte and queue the output beat it causes.
    function automatic void parse_capture_byte(logic [7:0] b);
        longint unsigned p;
        longint unsigned d;
        longint unsigned t;
        longint unsigned pay_end;
        bit              rec_done;
        bit              emit;
        bit              last;
        bit              has_payload;
        payload_or_end_t r;
        p        = rec_pos;
        rec_done = 1'b0;
        emit     = 1'b0;
        last     = 1'b0;
        if (p == 0) begin
            clear_record_fields();
        end
        if (p <= REC_HDR_LAST) begin
            // Record header: timestamps, then captured and original length (LE).
            if (p >= 8 && p < 12) begin
                cap_len_r[8*int'(p - 8) +: 8] = b;
            end else if (p >= 12) begin
                orig_len_r[8*int'(p - 12) +: 8] = b;
            end
            if (p == REC_HDR_LAST) begin
                if (cap_len_r != orig_len_r) begin
                    raise_status(ST_TRUNC);
                end
                if (cap_len_r == 0) begin
                    raise_status(ST_BAD_LEN);
                    rec_done = 1'b1;
                end
            end
        end else begin
            d       = p - (REC_HDR_LAST + 1);
            t       = ETH_HDR_BYTES + ip_hdr_bytes;
            pay_end = ETH_HDR_BYTES + ip_tot_len;
            // Fixed-offset Ethernet and IPv4 fields.
            if (d == OFS_ETYPE_HI) begin
                etype_hi_r = b;
            end else if (d == OFS_ETYPE_LO) begin
                if ({etype_hi_r, b} != ETHERTYPE_IPV4) begin
                    raise_status(ST_NOT_IPV4);
                end
            end else if (d == OFS_IP_VHL) begin
                ip_hdr_bytes = b[3:0] * 4;
                if (ip_hdr_bytes < MIN_HDR_BYTES) begin
                    raise_status(ST_BAD_LEN);
                end
            end else if (d == OFS_TOTLEN_HI) begin
                ip_tot_len = {16'h0000, b, 8'h00};
            end else if (d == OFS_TOTLEN_LO) begin
                ip_tot_len = ip_tot_len | b;
                if (ip_tot_len < ip_hdr_bytes + MIN_HDR_BYTES ||
                    ETH_HDR_BYTES + ip_tot_len > cap_len_r) begin
                    raise_status(ST_BAD_LEN);
                end
            end else if (d == OFS_PROTO) begin
                if (b != PROTO_TCP) begin
                    raise_status(ST_NOT_TCP);
                end
            end else if (d >= OFS_DST_FIRST && d <= OFS_DST_LAST) begin
                dst_r[8*int'(d - OFS_DST_FIRST) +: 8] = b;
            end
            // TCP header fields sit after the IPv4 options.
            if (d >= OFS_TCP_MIN) begin
                if (d >= t + 4 && d < t + 8) begin
                    seq_r = {seq_r[23:0], b};
                end else if (d == t + 12) begin
                    tcp_hdr_bytes = b[7:4] * 4;
                    if (tcp_hdr_bytes < MIN_HDR_BYTES ||
                        ip_hdr_bytes + tcp_hdr_bytes > ip_tot_len) begin
                        raise_status(ST_BAD_LEN);
                    end
                end else if (d == t + 13) begin
                    // Flags decide the connection phase for clean packets.
                    if (status_r == ST_OK) begin
                        has_payload = ip_tot_len > ip_hdr_bytes + tcp_hdr_bytes;
                        if (phase_r == PH_SEARCH) begin
                            if (b == SYN_ACK_FLAGS) begin
                                rx_addr = dst_r;
                                phase_r = PH_COLLECT;
                                keep_r  = has_payload;
                            end
                        end else if (phase_r == PH_COLLECT) begin
                            keep_r = has_payload && dst_r == rx_addr;
                            if ((b & TCP_FIN) != 0) begin
                                phase_r = PH_DONE;
                            end
                        end
                    end
                end else if (keep_r && d >= t + tcp_hdr_bytes && d < pay_end) begin
                    emit = 1'b1;
                    if (d + 1 == pay_end) begin
                        last   = 1'b1;
                        keep_r = 1'b0;
                    end
                end
            end
            if (d + 1 == cap_len_r) begin
                rec_done = 1'b1;
                if (cap_len_r < MIN_FRAME) begin
                    raise_status(ST_BAD_LEN);
                end
            end
        end
        rec_pos = rec_done ? 0 : p + 1;
        if (rec_done) begin
            keep_r = 1'b0;
        end
        if (emit || rec_done) begin
            r.data    = emit ? b : 8'h00;
            r.valid   = emit;
            r.last    = last;
            r.seq     = seq_r;
            r.dst     = dst_r;
            r.rec_end = rec_done;
            r.status  = rec_done ? status_r : ST_OK;
            r.done    = (phase_r != PH_SEARCH && phase_r != PH_COLLECT);
            payload_or_end_q.push_back(r);
        end
    endfunction

    // Offer one stream byte, with an occasional idle burst first, and wait for the request.
    task automatic push_stream_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        parse_capture_byte(b);
        bytes_sent++;
    endtask

    // A well-formed TCP segment; zero for ihl or doff picks a random header size.
    function automatic capture_pkt_t good_packet(logic [31:0] dst, logic [7:0] flags,
                                                 int plen, int trailer,
                                                 int ihl = 0, int doff = 0);
        capture_pkt_t pk;
        pk.ethertype = ETHERTYPE_IPV4;
        pk.proto     = PROTO_TCP;
        pk.dst       = dst;
        pk.seq       = $urandom;
        pk.flags     = flags;
        if (ihl != 0) begin
            pk.ihl = 4'(ihl);
        end else begin
            pk.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        end
        if (doff != 0) begin
            pk.doff = 4'(doff);
        end else begin
            pk.doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        end
        pk.total_len = 16'(pk.ihl * 4 + pk.doff * 4 + plen);
        pk.cap_len   = ETH_HDR_BYTES + pk.total_len + trailer;
        pk.orig_len  = pk.cap_len;
        return pk;
    endfunction

    // Build the record header and frame, then stream them byte by byte.
    task automatic send_record(input capture_pkt_t pk);
        logic [7:0] frame[$];
        int         i;
        for (i = 0; i < 8; i++) begin
            push_stream_byte(rand_byte());
        end
        for (i = 0; i < 4; i++) begin
            push_stream_byte(pk.cap_len[8*i +: 8]);
        end
        for (i = 0; i < 4; i++) begin
            push_stream_byte(pk.orig_len[8*i +: 8]);
        end
        // Ethernet and fixed IPv4 header.
        for (i = 0; i < 12; i++) begin
            frame.push_back(rand_byte());
        end
        frame.push_back(pk.ethertype[15:8]);
        frame.push_back(pk.ethertype[7:0]);
        frame.push_back({4'h4, pk.ihl});
        frame.push_back(rand_byte());
        frame.push_back(pk.total_len[15:8]);
        frame.push_back(pk.total_len[7:0]);
        for (i = 0; i < 5; i++) begin
            frame.push_back(rand_byte());
        end
        frame.push_back(pk.proto);
        for (i = 0; i < 6; i++) begin
            frame.push_back(rand_byte());
        end
        for (i = 0; i < 4; i++) begin
            frame.push_back(pk.dst[8*i +: 8]);
        end
        while (frame.size() < ETH_HDR_BYTES + pk.ihl * 4) begin
            frame.push_back(rand_byte());
        end
        // TCP header; options and payload are random filler.
        for (i = 0; i < 4; i++) begin
            frame.push_back(rand_byte());
        end
        for (i = 3; i >= 0; i--) begin
            frame.push_back(pk.seq[8*i +: 8]);
        end
        for (i = 0; i < 4; i++) begin
            frame.push_back(rand_byte());
        end
        frame.push_back({pk.doff, 4'($urandom)});
        frame.push_back(pk.flags);
        for (i = 0; i < pk.cap_len; i++) begin
            push_stream_byte(i < frame.size() ? frame[i] : rand_byte());
        end
    endtask

    // Random bytes behind a short, plausible record header.
    task automatic send_noise_record();
        logic [31:0] cap;
        logic [31:0] orig;
        int          i;
        cap  = $urandom_range(0, 40);
        orig = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 40)) : cap;
        for (i = 0; i < 8; i++) begin
            push_stream_byte(rand_byte());
        end
        for (i = 0; i < 4; i++) begin
            push_stream_byte(cap[8*i +: 8]);
        end
        for (i = 0; i < 4; i++) begin
            push_stream_byte(orig[8*i +: 8]);
        end
        for (i = 0; i < cap; i++) begin
            push_stream_byte(rand_byte());
        end
    endtask

    // Break one field of a good segment; none of these moves the flags byte.
    function automatic capture_pkt_t corrupt_packet(capture_pkt_t pk);
        case ($urandom_range(0, 6))
            0: pk.ethertype = 16'($urandom);
            1: pk.proto     = rand_byte();
            2: pk.ihl       = 4'($urandom_range(0, 4));
            3: pk.total_len = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, pk.total_len));
            4: pk.doff      = 4'($urandom);
            5: pk.orig_len  = ($urandom_range(0, 1) == 0) ? pk.cap_len + $urandom_range(1, 300)
                                                          : pk.cap_len - 1;
            default: begin
                pk.cap_len  = $urandom_range(0, pk.cap_len - 1);
                pk.orig_len = pk.cap_len;
            end
        endcase
        return pk;
    endfunction

    // Malformed and foreign records while still waiting for the handshake.
    task automatic test_record_faults();
        capture_pkt_t pk;
        pk = good_packet(32'h0a00_0001, TCP_ACK, 4, 0);
        pk.cap_len  = 32'h0;
        pk.orig_len = 32'h0;
        send_record(pk);
        pk.orig_len = 32'hffff_ffff;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 6, 0);
        pk.orig_len = pk.cap_len + 20;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 2, 0);
        pk.ethertype = ETHERTYPE_V6;
        send_record(pk);
        pk.orig_len = pk.cap_len + 1;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 2, 0);
        pk.proto = PROTO_UDP;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 2, 0, 5, 5);
        pk.ihl = 4'd0;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 0, 4, 5, 5);
        pk.total_len = 16'd39;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 3, 0);
        pk.cap_len  = pk.cap_len - 1;
        pk.orig_len = pk.cap_len;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 3, 0, 5, 5);
        pk.doff = 4'd4;
        send_record(pk);
        pk = good_packet($urandom, TCP_ACK, 10, 0, 5, 5);
        pk.doff = 4'd15;
        send_record(pk);
        // Records too short to reach the total length field.
        pk.cap_len  = 32'd17;
        pk.orig_len = 32'd17;
        send_record(pk);
        pk.cap_len  = 32'd1;
        pk.orig_len = 32'd1;
        send_record(pk);
        // Clean traffic that is not a handshake, with full options and a trailer.
        send_record(good_packet(32'hffff_ffff, 8'h18, 5, 6, 15, 15));
        // A faulty handshake must not open the connection.
        pk = good_packet(32'h0000_0000, SYN_ACK_FLAGS, 4, 0);
        pk.ethertype = ETHERTYPE_V6;
        send_record(pk);
    endtask

    // The handshake fixes the receiver; its own payload is already kept.
    task automatic test_handshake();
        receiver_dst = $urandom;
        send_record(good_packet(receiver_dst, SYN_ACK_FLAGS, 3, 0));
        send_record(good_packet(receiver_dst, TCP_ACK, 1, 0));
        send_record(good_packet(receiver_dst ^ 32'h0000_0100, TCP_ACK, 5, 0));
        send_record(good_packet(receiver_dst, TCP_ACK, 0, 4));
        send_record(good_packet(receiver_dst, 8'h18, 8, 3, 15, 15));
        send_record(good_packet($urandom, SYN_ACK_FLAGS, 4, 0));
    endtask

    // Mostly clean segments to the receiver, with foreign, broken and noise records.
    task automatic test_random_traffic();
        int           start;
        int           kind;
        int           plen;
        logic [31:0]  dst;
        logic [7:0]   flags;
        capture_pkt_t pk;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 4) != 0);
            kind    = $urandom_range(0, 99);
            plen    = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64)
                                                  : $urandom_range(0, 16);
            dst     = (kind < 55) ? receiver_dst : 32'($urandom);
            flags   = rand_byte() & ~TCP_FIN;
            pk      = good_packet(dst, flags, plen,
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
            if (kind < 70) begin
                send_record(pk);
            end else if (kind < 90) begin
                send_record(corrupt_packet(pk));
            end else begin
                send_noise_record();
            end
        end
        idle_on = 1'b1;
    endtask

    // FIN closes collection after its own payload; later records only report status.
    task automatic test_connection_close();
        capture_pkt_t pk;
        idle_on = 1'b0;
        send_record(good_packet(receiver_dst, TCP_ACK, 4, 0));
        send_record(good_packet(receiver_dst, TCP_FIN | TCP_ACK, 2, 0));
        send_record(good_packet(receiver_dst, TCP_ACK, 5, 0));
        send_record(good_packet(receiver_dst, SYN_ACK_FLAGS, 3, 2));
        pk = good_packet(receiver_dst, TCP_ACK, 3, 0);
        pk.proto = PROTO_UDP;
        send_record(pk);
        send_noise_record();
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Compare every accepted output beat with the oldest prediction.
    always @(posedge aclk) begin
        payload_or_end_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (payload_or_end_q.size() == 0) begin
                $display("%0t ns: output with nothing predicted: expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                e = payload_or_end_q.pop_front();
                check_field("payload_byte", e.data, m_tdata[7:0]);
                check_field("payload_valid", e.valid, m_tuser);
                check_field("payload_last", e.last, m_tlast);
                check_field("segment_sequence", e.seq, m_tdata[39:8]);
                check_field("packet_destination", e.dst, m_tdata[71:40]);
                check_field("record_end", e.rec_end, m_tdata[72]);
                check_field("record_status", e.status, m_tdata[75:73]);
                check_field("connection_done", e.done, m_tdata[76]);
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(posedge aclk) begin
        if (!aresetn || !idle_on) begin
            m_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither side moves a request.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[pcap_tcp_payload_extractor_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_record_fields();
        rec_pos = 0;
        rx_addr = '0;
        phase_r = PH_SEARCH;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_record_faults();
        test_handshake();
        test_random_traffic();
        test_connection_close();
        s_tvalid <= 1'b0;
        while (payload_or_end_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("[pcap_tcp_payload_extractor_core] OK");
        end else begin
            $display("[pcap_tcp_payload_extractor_core] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/ptpe_pkg.sv
sv/ptpe_in_stage.sv
sv/ptpe_parser.sv
sv/ptpe_out_stage.sv
sv/pcap_tcp_payload_extractor_core.sv
tb/tb_pcap_tcp_payload_extractor_core.sv
